// ===== hw/rtl/ccs_pkg.sv =====
// Shared widths, types and arithmetic step functions for the coherent complex sum core.
package ccs_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MAG_W        = SAMPLE_WIDTH + 1;
  localparam int SQ_IN_W      = 2 * MAG_W;
  localparam int SQ_REM_W     = MAG_W + 2;
  localparam int OUT_W        = SAMPLE_WIDTH + 3;
  localparam int CFG_W        = 16;
  localparam int PE_W         = CFG_W + MAG_W + 1;
  localparam int NUM_W        = MAG_W + OUT_W;
  localparam int DIV_REM_W    = MAG_W + 1;
  localparam int RND_SHIFT    = 15;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]        result_t;
  typedef logic        [MAG_W-1:0]        mag_t;

  // One digit of the square root: x supplies two bits per step from its top.
  typedef struct packed {
    logic [SQ_IN_W-1:0]  x;
    logic [SQ_REM_W-1:0] rem;
    mag_t                root;
  } sq_t;

  // One bit of the restoring division: low shifts dividend bits out and quotient bits in.
  typedef struct packed {
    logic [DIV_REM_W-1:0] rem;
    logic [OUT_W-1:0]     low;
  } dv_t;

  typedef struct packed {
    mag_t             usr;
    mag_t             usi;
    mag_t             m;
    logic [OUT_W-1:0] e;
    logic             neg_r;
    logic             neg_i;
    logic             fe;
  } ctx_t;

  function automatic sq_t sq_step(input sq_t s);
    sq_t                 o;
    logic [SQ_REM_W-1:0] sh;
    logic [SQ_REM_W-1:0] trial;
    sh    = {s.rem[SQ_REM_W-3:0], s.x[SQ_IN_W-1 -: 2]};
    trial = {s.root, 2'b01};
    o.x   = {s.x[SQ_IN_W-3:0], 2'b00};
    if (sh >= trial) begin
      o.rem  = sh - trial;
      o.root = {s.root[MAG_W-2:0], 1'b1};
    end else begin
      o.rem  = sh;
      o.root = {s.root[MAG_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t dv_step(input dv_t d, input mag_t m);
    dv_t                  o;
    logic [DIV_REM_W-1:0] sh;
    sh = {d.rem[DIV_REM_W-2:0], d.low[OUT_W-1]};
    if (sh >= {1'b0, m}) begin
      o.rem = sh - {1'b0, m};
      o.low = {d.low[OUT_W-2:0], 1'b1};
    end else begin
      o.rem = sh;
      o.low = {d.low[OUT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic result_t sat_out(input logic neg, input logic [OUT_W-1:0] mag);
    logic [OUT_W-1:0] lim;
    logic [OUT_W-1:0] v;
    lim = {1'b1, {(OUT_W-1){1'b0}}};
    if (neg) begin
      v = (mag > lim) ? lim : (~mag + 1'b1);
    end else begin
      v = mag[OUT_W-1] ? ~lim : mag;
    end
    return $signed(v);
  endfunction

endpackage

// ===== hw/rtl/coherent_complex_sum_core.sv =====
// Coherent complex sum of two wave field pixels: fully pipelined top level.
// The core takes one pixel pair per clock while in_ready is high and returns one result per
// pixel, in order. Each request passes 65 register stages on its way to out_valid. Most of
// them lie in the two pipelined square root units (17 stages each, one root bit per stage,
// behind a load stage), the restoring divider (19 stages, one quotient bit per stage) and
// the multiply and rounding stages between them. A two-entry output buffer lets the
// pipeline keep taking requests while a result waits; in_ready falls only once both
// entries are full. The coherence register should be written only while no pixel is in
// flight.
module coherent_complex_sum_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [ccs_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ccs_pkg::sample_t       in_first_real,
  input  ccs_pkg::sample_t       in_first_imag,
  input  ccs_pkg::sample_t       in_second_real,
  input  ccs_pkg::sample_t       in_second_imag,
  input  logic                   in_frame_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ccs_pkg::result_t       out_sum_real,
  output ccs_pkg::result_t       out_sum_imag,
  output logic                   out_frame_end_out
);
  import ccs_pkg::*;

  logic             en;
  logic [CFG_W-1:0] coh_r;

  // Input stage
  logic    v1_r;
  sample_t ar_r, ai_r, br_r, bi_r;
  logic    fe1_r;

  // Magnitude stage
  logic v2_r;
  mag_t uar_r, uai_r, ubr_r, ubi_r;
  ctx_t ctx2_r;
  logic signed [MAG_W-1:0] sr_nxt, si_nxt;

  // Square stage
  logic               v3_r;
  logic [SQ_IN_W-1:0] par_r, pai_r, pbr_r, pbi_r, psr_r, psi_r;
  ctx_t               ctx3_r;

  // First square root pipeline: |a|, |b| and |s| side by side
  logic [MAG_W:0] vq_r;
  sq_t            sqa_r [0:MAG_W];
  sq_t            sqb_r [0:MAG_W];
  sq_t            sqs_r [0:MAG_W];
  ctx_t           ctxq_r [0:MAG_W];

  // Second square root pipeline: sqrt(|a|*|b|)
  logic [MAG_W:0] vt_r;
  sq_t            sqt_r [0:MAG_W];
  ctx_t           ctxt_r [0:MAG_W];
  ctx_t           ctxt_nxt;

  // Coherence term and numerators
  logic             v6_r, v7_r, v8_r, v9_r;
  logic [PE_W-1:0]  pe_r;
  logic [PE_W-1:0]  pe_rnd;
  ctx_t             ctx6_r, ctx7_r, ctx8_r, ctx9_r;
  ctx_t             ctx7_nxt;
  logic [OUT_W-1:0] sum_r;
  logic [NUM_W-1:0] nr_r, ni_r;
  logic [NUM_W-1:0] numr_nxt, numi_nxt;

  // Divider pipeline
  logic [OUT_W:0] vd_r;
  dv_t            dvr_r [0:OUT_W];
  dv_t            dvi_r [0:OUT_W];
  ctx_t           ctxd_r [0:OUT_W];

  // Final stage and output buffer
  logic    v_fin_r;
  result_t fin_real_r, fin_imag_r;
  logic    fin_fe_r;
  logic    out_valid_r, skid_full_r;
  result_t out_real_r, out_imag_r, skid_real_r, skid_imag_r;
  logic    out_fe_r, skid_fe_r;

  assign en       = !skid_full_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coh_r <= '0;
    end else if (cfg_wr_en) begin
      coh_r <= cfg_wr_data;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      vq_r    <= '0;
      vt_r    <= '0;
      v6_r    <= 1'b0;
      v7_r    <= 1'b0;
      v8_r    <= 1'b0;
      v9_r    <= 1'b0;
      vd_r    <= '0;
      v_fin_r <= 1'b0;
    end else if (en) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      vq_r    <= {vq_r[MAG_W-1:0], v3_r};
      vt_r    <= {vt_r[MAG_W-1:0], vq_r[MAG_W]};
      v6_r    <= vt_r[MAG_W];
      v7_r    <= v6_r;
      v8_r    <= v7_r;
      v9_r    <= v8_r;
      vd_r    <= {vd_r[OUT_W-1:0], v9_r};
      v_fin_r <= vd_r[OUT_W];
    end
  end

  always_comb begin
    sr_nxt     = MAG_W'(ar_r) + MAG_W'(br_r);
    si_nxt     = MAG_W'(ai_r) + MAG_W'(bi_r);
    pe_rnd     = pe_r + PE_W'(1 << (RND_SHIFT - 1));
    numr_nxt   = nr_r + NUM_W'(ctx9_r.m >> 1);
    numi_nxt   = ni_r + NUM_W'(ctx9_r.m >> 1);
    ctxt_nxt   = ctxq_r[MAG_W];
    ctxt_nxt.m = sqs_r[MAG_W].root;
    ctx7_nxt   = ctx6_r;
    ctx7_nxt.e = pe_rnd[RND_SHIFT +: OUT_W];
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (en) begin
      ar_r  <= in_first_real;
      ai_r  <= in_first_imag;
      br_r  <= in_second_real;
      bi_r  <= in_second_imag;
      fe1_r <= in_frame_end;

      uar_r <= ar_r[SAMPLE_WIDTH-1] ? -MAG_W'(ar_r) : MAG_W'(ar_r);
      uai_r <= ai_r[SAMPLE_WIDTH-1] ? -MAG_W'(ai_r) : MAG_W'(ai_r);
      ubr_r <= br_r[SAMPLE_WIDTH-1] ? -MAG_W'(br_r) : MAG_W'(br_r);
      ubi_r <= bi_r[SAMPLE_WIDTH-1] ? -MAG_W'(bi_r) : MAG_W'(bi_r);
      ctx2_r.usr   <= sr_nxt[MAG_W-1] ? mag_t'(-sr_nxt) : mag_t'(sr_nxt);
      ctx2_r.usi   <= si_nxt[MAG_W-1] ? mag_t'(-si_nxt) : mag_t'(si_nxt);
      ctx2_r.neg_r <= sr_nxt[MAG_W-1];
      ctx2_r.neg_i <= si_nxt[MAG_W-1];
      ctx2_r.fe    <= fe1_r;
      ctx2_r.m     <= '0;
      ctx2_r.e     <= '0;

      par_r  <= uar_r * uar_r;
      pai_r  <= uai_r * uai_r;
      pbr_r  <= ubr_r * ubr_r;
      pbi_r  <= ubi_r * ubi_r;
      psr_r  <= ctx2_r.usr * ctx2_r.usr;
      psi_r  <= ctx2_r.usi * ctx2_r.usi;
      ctx3_r <= ctx2_r;

      sqa_r[0]  <= '{x: par_r + pai_r, rem: '0, root: '0};
      sqb_r[0]  <= '{x: pbr_r + pbi_r, rem: '0, root: '0};
      sqs_r[0]  <= '{x: psr_r + psi_r, rem: '0, root: '0};
      ctxq_r[0] <= ctx3_r;
      for (int k = 0; k < MAG_W; k++) begin
        sqa_r[k+1]  <= sq_step(sqa_r[k]);
        sqb_r[k+1]  <= sq_step(sqb_r[k]);
        sqs_r[k+1]  <= sq_step(sqs_r[k]);
        ctxq_r[k+1] <= ctxq_r[k];
      end

      sqt_r[0]  <= '{x: sqa_r[MAG_W].root * sqb_r[MAG_W].root, rem: '0, root: '0};
      ctxt_r[0] <= ctxt_nxt;
      for (int k = 0; k < MAG_W; k++) begin
        sqt_r[k+1]  <= sq_step(sqt_r[k]);
        ctxt_r[k+1] <= ctxt_r[k];
      end

      // Twice coherence times the geometric mean, rounded half up to the sample LSB.
      pe_r   <= {(PE_W-1)'(coh_r) * (PE_W-1)'(sqt_r[MAG_W].root), 1'b0};
      ctx6_r <= ctxt_r[MAG_W];

      ctx7_r <= ctx7_nxt;

      sum_r  <= OUT_W'(ctx7_r.m) + ctx7_r.e;
      ctx8_r <= ctx7_r;

      nr_r   <= ctx8_r.usr * sum_r;
      ni_r   <= ctx8_r.usi * sum_r;
      ctx9_r <= ctx8_r;

      dvr_r[0]  <= '{rem: DIV_REM_W'(numr_nxt[NUM_W-1:OUT_W]), low: numr_nxt[OUT_W-1:0]};
      dvi_r[0]  <= '{rem: DIV_REM_W'(numi_nxt[NUM_W-1:OUT_W]), low: numi_nxt[OUT_W-1:0]};
      ctxd_r[0] <= ctx9_r;
      for (int k = 0; k < OUT_W; k++) begin
        dvr_r[k+1]  <= dv_step(dvr_r[k], ctxd_r[k].m);
        dvi_r[k+1]  <= dv_step(dvi_r[k], ctxd_r[k].m);
        ctxd_r[k+1] <= ctxd_r[k];
      end

      // A zero sum has no phase of its own, so the result lies on the real axis.
      if (ctxd_r[OUT_W].m == '0) begin
        fin_real_r <= sat_out(1'b0, ctxd_r[OUT_W].e);
        fin_imag_r <= '0;
      end else begin
        fin_real_r <= sat_out(ctxd_r[OUT_W].neg_r, dvr_r[OUT_W].low);
        fin_imag_r <= sat_out(ctxd_r[OUT_W].neg_i, dvi_r[OUT_W].low);
      end
      fin_fe_r <= ctxd_r[OUT_W].fe;
    end
  end

  // Output register with one spare entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      if (v_fin_r && en) begin
        skid_full_r <= 1'b1;
      end
    end else if (skid_full_r) begin
      out_valid_r <= 1'b1;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= v_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ready) begin
      if (v_fin_r && en) begin
        skid_real_r <= fin_real_r;
        skid_imag_r <= fin_imag_r;
        skid_fe_r   <= fin_fe_r;
      end
    end else if (skid_full_r) begin
      out_real_r <= skid_real_r;
      out_imag_r <= skid_imag_r;
      out_fe_r   <= skid_fe_r;
    end else begin
      out_real_r <= fin_real_r;
      out_imag_r <= fin_imag_r;
      out_fe_r   <= fin_fe_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sum_real      = out_real_r;
  assign out_sum_imag      = out_imag_r;
  assign out_frame_end_out = out_fe_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("spare entry holds a request while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && !out_ready && v_fin_r))
    else $error("spare entry filled without a stalled output and a finished request");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_fin_r) && $stable(vd_r) && $stable(vq_r))
    else $error("pipeline moved while stalled");

endmodule
